>>> rtl/pid_position_motor_drive_macros.svh
// Assertion macros shared by the RTL of the motor drive position loop.
// Define ASSERT_OFF to compile every check down to nothing.
`ifndef PID_POSITION_MOTOR_DRIVE_MACROS_SVH
`define PID_POSITION_MOTOR_DRIVE_MACROS_SVH

`ifndef ASSERT_OFF

// A property checked at every rising edge outside reset.
`define PMD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// A condition that must be followed in the next cycle by a consequence.
`define PMD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PMD_ASSERT(lbl, clk, rstn, prop, msg)
`define PMD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> rtl/pmd_pkg.sv
package pmd_pkg;

    // Field and datapath widths.
    localparam int POS_W     = 16;
    localparam int GAIN_W    = 16;
    localparam int MAG_W     = 32;
    localparam int PROD_W    = MAG_W + GAIN_W;
    localparam int SIG_W     = PROD_W + 2;
    localparam int CFG_IDX_W = 3;

    // The divider retires two quotient bits per cycle.
    localparam int DIV_STEPS = PROD_W / 2;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DIVISOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY     = 3'd4;

    // Register values after reset.
    localparam logic [GAIN_W-1:0] RST_PROP_GAIN    = 16'd5000;
    localparam logic [GAIN_W-1:0] RST_INTEG_GAIN   = 16'd1;
    localparam logic [GAIN_W-1:0] RST_DERIV_GAIN   = 16'd1000;
    localparam logic [GAIN_W-1:0] RST_GAIN_DIVISOR = 16'd100;
    localparam logic [GAIN_W-1:0] RST_MAX_DUTY     = 16'd0;

    // Term codes walked by the sequencer.
    localparam logic [1:0] TERM_PROP  = 2'd0;
    localparam logic [1:0] TERM_INTEG = 2'd1;
    localparam logic [1:0] TERM_DERIV = 2'd2;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain;
        logic [GAIN_W-1:0] deriv_gain;
        logic [GAIN_W-1:0] gain_divisor;
        logic [GAIN_W-1:0] max_duty;
    } cfg_regs_t;

    // Launch of one multiply and divide on the shared unit.
    typedef struct packed {
        logic              start;
        logic [MAG_W-1:0]  mag;
        logic [GAIN_W-1:0] gain;
        logic [GAIN_W-1:0] divisor;
    } md_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [PROD_W-1:0] quot;
    } md_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_WAIT,
        ST_FINISH
    } pmd_state_t;

endpackage

>>> rtl/pmd_cfg.sv
module pmd_cfg
    import pmd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [GAIN_W-1:0]    cfg_data,
    output cfg_regs_t            regs
);

    cfg_regs_t regs_reg;

    // The register file takes a write in any cycle.
    assign cfg_ready = 1'b1;
    assign regs      = regs_reg;

    // Writes to an index beyond the register list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg.prop_gain    <= RST_PROP_GAIN;
            regs_reg.integ_gain   <= RST_INTEG_GAIN;
            regs_reg.deriv_gain   <= RST_DERIV_GAIN;
            regs_reg.gain_divisor <= RST_GAIN_DIVISOR;
            regs_reg.max_duty     <= RST_MAX_DUTY;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PROP_GAIN:    regs_reg.prop_gain    <= cfg_data;
                REG_INTEG_GAIN:   regs_reg.integ_gain   <= cfg_data;
                REG_DERIV_GAIN:   regs_reg.deriv_gain   <= cfg_data;
                REG_GAIN_DIVISOR: regs_reg.gain_divisor <= cfg_data;
                REG_MAX_DUTY:     regs_reg.max_duty     <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/pmd_muldiv.sv
module pmd_muldiv
    import pmd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  md_req_t req,
    output md_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [PROD_W-1:0] quo_reg;
    logic [PROD_W-1:0] quo_next;
    logic [GAIN_W-1:0] rem_reg;
    logic [GAIN_W-1:0] rem_next;
    logic [GAIN_W-1:0] div_reg;
    logic [PROD_W-1:0] prod;
    logic [GAIN_W:0]   trial_a;
    logic [GAIN_W:0]   trial_b;
    logic [PROD_W-1:0] quo_mid;
    logic [GAIN_W-1:0] rem_mid;

    // The product is taken straight into the dividend shift register.
    assign prod = req.mag * req.gain;

    // Two restoring steps per cycle. The remainder stays below the divisor,
    // so it always fits in the divisor's width.
    always_comb begin
        trial_a = {rem_reg, quo_reg[PROD_W-1]};
        quo_mid = {quo_reg[PROD_W-2:0], 1'b0};
        if (trial_a >= {1'b0, div_reg}) begin
            rem_mid    = GAIN_W'(trial_a - {1'b0, div_reg});
            quo_mid[0] = 1'b1;
        end else begin
            rem_mid    = trial_a[GAIN_W-1:0];
        end

        trial_b  = {rem_mid, quo_mid[PROD_W-1]};
        quo_next = {quo_mid[PROD_W-2:0], 1'b0};
        if (trial_b >= {1'b0, div_reg}) begin
            rem_next    = GAIN_W'(trial_b - {1'b0, div_reg});
            quo_next[0] = 1'b1;
        end else begin
            rem_next    = trial_b[GAIN_W-1:0];
        end
    end

    // Step control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= prod;
            rem_reg <= '0;
            div_reg <= req.divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // Status and quotient, packed as busy, done, quotient from the top down.
    assign rsp = {busy_reg, done_reg, quo_reg};

endmodule

>>> rtl/pid_position_motor_drive.sv
// Channel   Direction  Payload
// s_axis    in         tdata: position, target, feedforward; tuser: enable
// m_axis    out        tdata: duty; tuser: reverse
// cfg       in         cfg_index selects the register, cfg_data is the value
//
// After an enabled tick is accepted, the input side is not ready until three terms
// have run in turn on the shared multiply and divide unit, whose 48-bit quotient
// comes out two bits per cycle, and the result is loaded. A skipped tick is dropped.
// The result is registered and waits for m_axis_tready without holding back the
// next request. Reset is synchronous and active low; nothing is cleared by sweep.
`include "pid_position_motor_drive_macros.svh"

module pid_position_motor_drive
    import pmd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [47:0]          s_axis_tdata,  // position, target, feedforward
    input  logic                 s_axis_tuser,  // enable

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata,  // duty
    output logic                 m_axis_tuser,  // reverse

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [GAIN_W-1:0]    cfg_data
);

    cfg_regs_t  cfg;
    md_req_t    md_req;
    md_rsp_t    md_rsp;
    pmd_state_t state_reg;
    pmd_state_t state_next;

    logic [POS_W:0]        err_reg;
    logic [POS_W:0]        dpos_reg;
    logic [MAG_W-1:0]      integral_reg;
    logic [POS_W-1:0]      last_pos_reg;
    logic [SIG_W-1:0]      sig_reg;
    logic [1:0]            term_reg;
    logic                  m_valid_reg;
    logic [POS_W-1:0]      duty_reg;
    logic                  rev_reg;

    logic [POS_W-1:0]      in_pos;
    logic [POS_W-1:0]      in_tgt;
    logic [POS_W-1:0]      in_ff;
    logic                  accept_run;
    logic                  term_done;
    logic                  out_load;
    logic                  md_start;
    logic [GAIN_W-1:0]     div_sel;
    logic [POS_W:0]        err_w;
    logic [POS_W:0]        dpos_w;
    logic [MAG_W:0]        integ_sum;
    logic [MAG_W-1:0]      integ_sat;
    logic [MAG_W:0]        op_val;
    logic [MAG_W:0]        op_abs;
    logic [GAIN_W-1:0]     op_gain;
    logic [SIG_W-1:0]      quot_ext;
    logic [SIG_W-1:0]      term_val;
    logic [SIG_W-1:0]      sig_abs;
    logic [POS_W-1:0]      duty_w;

    pmd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (cfg)
    );

    pmd_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .rsp     (md_rsp)
    );

    assign in_pos = s_axis_tdata[15:0];
    assign in_tgt = s_axis_tdata[31:16];
    assign in_ff  = s_axis_tdata[47:32];

    // Position error, measured change and the saturating integral update.
    assign err_w     = {in_pos[POS_W-1], in_pos} - {in_tgt[POS_W-1], in_tgt};
    assign dpos_w    = {in_pos[POS_W-1], in_pos} - {last_pos_reg[POS_W-1], last_pos_reg};
    assign integ_sum = {integral_reg[MAG_W-1], integral_reg}
                     + {{(MAG_W-POS_W){err_w[POS_W]}}, err_w};

    always_comb begin
        if (integ_sum[MAG_W] != integ_sum[MAG_W-1]) begin
            integ_sat = integ_sum[MAG_W] ? {1'b1, {(MAG_W-1){1'b0}}}
                                         : {1'b0, {(MAG_W-1){1'b1}}};
        end else begin
            integ_sat = integ_sum[MAG_W-1:0];
        end
    end

    // Operand of the current term, split into sign and magnitude.
    always_comb begin
        case (term_reg)
            TERM_PROP: begin
                op_val  = {{(MAG_W-POS_W){err_reg[POS_W]}}, err_reg};
                op_gain = cfg.prop_gain;
            end
            TERM_INTEG: begin
                op_val  = {integral_reg[MAG_W-1], integral_reg};
                op_gain = cfg.integ_gain;
            end
            TERM_DERIV: begin
                op_val  = {{(MAG_W-POS_W){dpos_reg[POS_W]}}, dpos_reg};
                op_gain = cfg.deriv_gain;
            end
            default: begin
                op_val  = '0;
                op_gain = '0;
            end
        endcase
        op_abs = op_val[MAG_W] ? -op_val : op_val;
    end

    // Launch request for the shared unit: start, magnitude, gain, divisor.
    assign div_sel = (cfg.gain_divisor == '0) ? GAIN_W'(1) : cfg.gain_divisor;
    assign md_req  = {md_start, op_abs[MAG_W-1:0], op_gain, div_sel};

    // The quotient takes the operand's sign, so it truncates toward zero.
    assign quot_ext = {{(SIG_W-PROD_W){1'b0}}, md_rsp.quot};
    assign term_val = op_val[MAG_W] ? -quot_ext : quot_ext;

    // Magnitude clamp and direction of the finished sum.
    assign sig_abs = sig_reg[SIG_W-1] ? -sig_reg : sig_reg;
    assign duty_w  = (sig_abs > {{(SIG_W-GAIN_W){1'b0}}, cfg.max_duty})
                   ? cfg.max_duty : sig_abs[POS_W-1:0];

    // Sequencer: next state and strobes.
    always_comb begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        md_start      = 1'b0;
        accept_run    = 1'b0;
        term_done     = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && s_axis_tuser) begin
                    accept_run = 1'b1;
                    state_next = ST_LAUNCH;
                end
            end
            ST_LAUNCH: begin
                md_start   = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (md_rsp.done) begin
                    term_done  = 1'b1;
                    state_next = (term_reg == TERM_DERIV) ? ST_FINISH : ST_LAUNCH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_axis_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state, loop state and the output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            term_reg     <= TERM_PROP;
            integral_reg <= '0;
            last_pos_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept_run) begin
                term_reg     <= TERM_PROP;
                integral_reg <= integ_sat;
                last_pos_reg <= in_pos;
            end else if (term_done && term_reg != TERM_DERIV) begin
                term_reg <= term_reg + 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers and the result register.
    always_ff @(posedge aclk) begin
        if (accept_run) begin
            err_reg  <= err_w;
            dpos_reg <= dpos_w;
            sig_reg  <= {{(SIG_W-POS_W){in_ff[POS_W-1]}}, in_ff};
        end else if (term_done) begin
            sig_reg <= sig_reg + term_val;
        end
        if (out_load) begin
            duty_reg <= duty_w;
            rev_reg  <= sig_reg[SIG_W-1];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = duty_reg;
    assign m_axis_tuser  = rev_reg;

    // The shared unit only runs or reports while the sequencer waits on it.
    `PMD_ASSERT(a_busy_in_wait, aclk, aresetn,
        md_rsp.busy |-> (state_reg == ST_WAIT), "muldiv busy outside wait state")
    `PMD_ASSERT(a_done_in_wait, aclk, aresetn,
        md_rsp.done |-> (state_reg == ST_WAIT), "muldiv done outside wait state")
    `PMD_ASSERT(a_term_range, aclk, aresetn,
        term_reg <= TERM_DERIV, "term counter out of range")
    `PMD_ASSERT_NEXT(a_skip_keeps_state, aclk, aresetn,
        s_axis_tvalid && s_axis_tready && !s_axis_tuser,
        $stable(integral_reg) && $stable(last_pos_reg) && (state_reg == ST_IDLE),
        "skipped tick changed loop state")

endmodule
